FILE: hw/rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants for the frame deframer
// Result kinds, parse phases, opcodes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam logic [31:0] MAX_LEN_RESET = 32'd8388608;
	localparam int          QUEUE_DEPTH   = 4;

	typedef enum logic [2:0] {
		KIND_TEXT       = 3'd0,
		KIND_TEXT_END   = 3'd1,
		KIND_DISCARD    = 3'd2,
		KIND_PONG       = 3'd3,
		KIND_PONG_EMPTY = 3'd4,
		KIND_CLOSE      = 3'd5,
		KIND_ERROR      = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		PH_HDR0  = 3'd0,
		PH_HDR1  = 3'd1,
		PH_EXT16 = 3'd2,
		PH_EXT64 = 3'd3,
		PH_MASK  = 3'd4,
		PH_PAY   = 3'd5
	} phase_t;

	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	// one queued result pair; a step gives at most two results
	typedef struct packed {
		logic  v0;
		kind_t k0;
		logic [7:0] d0;
		logic  l0;
		logic  v1;
		kind_t k1;
		logic  l1;
	} res_pair_t;

endpackage

FILE: hw/rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser: frame header and payload parser
// Updates the parse state per byte and produces up to two results.
// ----------------------------------------------------------------------------
module wsd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          in_byte,
	input  logic [31:0]         max_len,
	output wsd_pkg::res_pair_t  res
);

	wsd_pkg::phase_t phase_q, phase_d;
	logic        fin_q, fin_d;
	logic [3:0]  op_q, op_d;
	logic        masked_q, masked_d;
	logic [63:0] len_q, len_d;
	logic [2:0]  hcnt_q, hcnt_d;
	logic [31:0] key_q, key_d;
	logic [63:0] idx_q, idx_d;
	logic [1:0]  mtype_q, mtype_d;
	logic        mopen_q, mopen_d;
	logic        stop_q, stop_d;

	logic        op_ok;
	logic        do_len, do_hdr, do_end;
	logic [63:0] len_new;
	logic [7:0]  key_byte, data;
	logic        final_byte;

	always_comb begin
		phase_d = phase_q; fin_d = fin_q; op_d = op_q; masked_d = masked_q;
		len_d = len_q; hcnt_d = hcnt_q; key_d = key_q; idx_d = idx_q;
		mtype_d = mtype_q; mopen_d = mopen_q; stop_d = stop_q;
		res = '0;
		res.k0 = wsd_pkg::KIND_TEXT;
		res.k1 = wsd_pkg::KIND_TEXT;
		do_len = 1'b0; do_hdr = 1'b0; do_end = 1'b0;
		len_new = len_q;
		final_byte = (idx_q + 64'd1) == len_q;
		case (idx_q[1:0])
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
		data = in_byte ^ key_byte;
		op_ok = 1'b0;
		if (!stop_q) begin
			case (phase_q)
				wsd_pkg::PH_HDR0: begin
					fin_d = in_byte[7];
					op_d = in_byte[3:0];
					key_d = '0;
					phase_d = wsd_pkg::PH_HDR1;
				end
				wsd_pkg::PH_HDR1: begin
					masked_d = in_byte[7];
					hcnt_d = '0;
					if (in_byte[6:0] == wsd_pkg::LEN_CODE_16) begin
						len_d = '0;
						phase_d = wsd_pkg::PH_EXT16;
					end else if (in_byte[6:0] == wsd_pkg::LEN_CODE_64) begin
						len_d = '0;
						phase_d = wsd_pkg::PH_EXT64;
					end else begin
						len_new = {57'd0, in_byte[6:0]};
						len_d = len_new;
						do_len = 1'b1;
					end
				end
				wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
					len_new = {len_q[55:0], in_byte};
					len_d = len_new;
					if (hcnt_q >= ((phase_q == wsd_pkg::PH_EXT16) ? 3'd1 : 3'd7))
						do_len = 1'b1;
					else
						hcnt_d = hcnt_q + 3'd1;
				end
				wsd_pkg::PH_MASK: begin
					key_d = {key_q[23:0], in_byte};
					if (hcnt_q >= 3'd3)
						do_hdr = 1'b1;
					else
						hcnt_d = hcnt_q + 3'd1;
				end
				wsd_pkg::PH_PAY: begin
					if (op_q == wsd_pkg::OP_TEXT ||
					    (op_q == wsd_pkg::OP_CONT && mtype_q == 2'd1)) begin
						res.v0 = 1'b1;
						res.k0 = wsd_pkg::KIND_TEXT;
						res.d0 = data;
						res.l0 = final_byte & fin_q;
					end else if (op_q == wsd_pkg::OP_PING) begin
						res.v0 = 1'b1;
						res.k0 = wsd_pkg::KIND_PONG;
						res.d0 = data;
						res.l0 = final_byte;
					end
					idx_d = idx_q + 64'd1;
					if (final_byte) do_end = 1'b1;
				end
				default: phase_d = wsd_pkg::PH_HDR0;
			endcase

			// length complete
			if (do_len) begin
				if (len_new > {32'd0, max_len}) begin
					stop_d = 1'b1;
					phase_d = wsd_pkg::PH_HDR0;
					res.v0 = 1'b1;
					res.k0 = wsd_pkg::KIND_ERROR;
				end else if (masked_d) begin
					hcnt_d = '0;
					phase_d = wsd_pkg::PH_MASK;
				end else begin
					do_hdr = 1'b1;
				end
			end
			// header complete; discard uses slot 0, frame end uses slot 1
			if (do_hdr) begin
				if (op_d == wsd_pkg::OP_TEXT || op_d == wsd_pkg::OP_BIN) begin
					if (mopen_q && mtype_q == 2'd1) begin
						res.v0 = 1'b1;
						res.k0 = wsd_pkg::KIND_DISCARD;
					end
					mtype_d = op_d[1:0];
					mopen_d = !fin_d;
				end else if (op_d == wsd_pkg::OP_CONT) begin
					mopen_d = !fin_d;
				end
				idx_d = '0;
				if (len_d == 64'd0) do_end = 1'b1;
				else phase_d = wsd_pkg::PH_PAY;
			end
			if (do_end) begin
				op_ok = op_d == wsd_pkg::OP_CONT || op_d == wsd_pkg::OP_TEXT ||
					op_d == wsd_pkg::OP_BIN || op_d == wsd_pkg::OP_CLOSE ||
					op_d == wsd_pkg::OP_PING || op_d == wsd_pkg::OP_PONG;
				if (!op_ok) begin
					res.v1 = 1'b1; res.k1 = wsd_pkg::KIND_ERROR; stop_d = 1'b1;
				end else if (op_d == wsd_pkg::OP_CLOSE) begin
					res.v1 = 1'b1; res.k1 = wsd_pkg::KIND_CLOSE; stop_d = 1'b1;
				end else if (op_d == wsd_pkg::OP_PING) begin
					if (len_d == 64'd0) begin
						res.v1 = 1'b1; res.k1 = wsd_pkg::KIND_PONG_EMPTY; res.l1 = 1'b1;
					end
				end else if (op_d == wsd_pkg::OP_CONT || op_d == wsd_pkg::OP_TEXT) begin
					if (len_d == 64'd0 && fin_d && mtype_d == 2'd1) begin
						res.v1 = 1'b1; res.k1 = wsd_pkg::KIND_TEXT_END; res.l1 = 1'b1;
					end
				end
				phase_d = wsd_pkg::PH_HDR0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wsd_pkg::PH_HDR0;
			fin_q <= 1'b0; op_q <= '0; masked_q <= 1'b0; len_q <= '0;
			hcnt_q <= '0; key_q <= '0; idx_q <= '0; mtype_q <= '0;
			mopen_q <= 1'b0; stop_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			fin_q <= fin_d; op_q <= op_d; masked_q <= masked_d; len_q <= len_d;
			hcnt_q <= hcnt_d; key_q <= key_d; idx_q <= idx_d; mtype_q <= mtype_d;
			mopen_q <= mopen_d; stop_q <= stop_d;
		end
	end

endmodule

FILE: hw/rtl/wsd_queue.sv
// ----------------------------------------------------------------------------
// wsd_queue: result pair queue
// Small FIFO between the parser and the output serialiser.
// ----------------------------------------------------------------------------
module wsd_queue #(
	parameter int DEPTH = wsd_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  wsd_pkg::res_pair_t wr_data,
	output logic               full,
	output logic               empty,
	input  logic               rd_en,
	output wsd_pkg::res_pair_t rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	wsd_pkg::res_pair_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full    = cnt_q == (AW+1)'(DEPTH);
	assign empty   = cnt_q == '0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd_en) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end

endmodule

FILE: hw/rtl/wsd_emitter.sv
// ----------------------------------------------------------------------------
// wsd_emitter: output serialiser
// Presents queued result pairs one result at a time on the output channel.
// ----------------------------------------------------------------------------
module wsd_emitter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  wsd_pkg::res_pair_t q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         kind,
	output logic [7:0]         data_byte,
	output logic               last
);

	logic sel_q; // slot 0 already delivered
	logic use0;

	assign use0      = q_data.v0 && !sel_q;
	assign out_valid = !q_empty;
	assign kind      = use0 ? q_data.k0 : q_data.k1;
	assign data_byte = use0 ? q_data.d0 : 8'd0;
	assign last      = use0 ? q_data.l0 : q_data.l1;
	assign q_pop     = out_valid && out_ready && !(use0 && q_data.v1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sel_q <= 1'b0;
		else if (out_valid && out_ready) sel_q <= !q_pop;
	end

endmodule

FILE: hw/rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer: streaming frame parser
// Parses frames byte by byte; emits unmasked text/ping bytes and status results.
// ----------------------------------------------------------------------------
// One byte is taken per clock whenever the result queue has room; each byte's
// full header/payload step is done in the cycle it is accepted, and its zero to
// two results enter a four-entry queue. Results leave one per clock while the
// receiver is ready; the queue absorbs double results, and input only stalls
// while the queue is full, which double results in a row or a stalled receiver
// can cause; otherwise throughput is one byte per cycle. Results are registered
// in the queue before they reach the output. After a close or error further
// bytes are accepted and ignored until reset.
module websocket_frame_deframer #(
	parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] max_payload_length,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  data_byte,
	output logic        last
);

	logic [31:0] max_len_q;
	wsd_pkg::res_pair_t res, q_rd;
	logic step, full, empty, pop, push;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_len_q <= wsd_pkg::MAX_LEN_RESET;
		else if (cfg_valid) max_len_q <= max_payload_length;
	end

	// front: accept when the queue can take a transaction's results
	assign in_ready = !full;
	assign step     = in_valid && in_ready;
	assign push     = step && (res.v0 || res.v1);

	wsd_parser u_parser (
		.clk, .arst_n, .step, .in_byte, .max_len(max_len_q), .res
	);

	wsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .wr_en(push), .wr_data(res), .full, .empty,
		.rd_en(pop), .rd_data(q_rd)
	);

	// back: serialise result pairs
	wsd_emitter u_emit (
		.clk, .arst_n, .q_empty(empty), .q_data(q_rd), .q_pop(pop),
		.out_valid, .out_ready, .kind, .data_byte, .last
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != wsd_pkg::KIND_TEXT && kind != wsd_pkg::KIND_PONG)
		|-> data_byte == 8'd0) else $error("data on non-byte kind");
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind != 3'd7) else $error("bad kind");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for websocket_frame_deframer
// Frames are built as byte streams and pushed through the input channel; an
// in-bench deframer predicts each result, and the monitor checks every output
// transaction against the oldest prediction. The limit register is rewritten
// between phases while the block is quiet.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 400000;
	localparam int QUIET_CYCLES = 8;

	typedef struct {
		bit          is_cfg;
		logic [31:0] val;
	} pend_t;

	typedef struct {
		wsd_pkg::kind_t k;
		logic [7:0]     d;
		logic           l;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] max_payload_length;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  kind;
	logic [7:0]  data_byte;
	logic        last;

	websocket_frame_deframer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.max_payload_length(max_payload_length),
		.in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .data_byte(data_byte), .last(last)
	);

	pend_t   pending_tx[$];
	result_t expected_results[$];
	int      error_count = 0;
	int      bytes_taken = 0;
	int      quiet_count = 0;
	int      cycle_count = 0;

	// predictor state, mirrors the block's parse state
	logic [31:0]       len_limit;
	wsd_pkg::phase_t   ph;
	logic              fin_f;
	logic [3:0]        opc;
	logic              masked_f;
	logic [63:0]       pay_len;
	logic [2:0]        hdr_cnt;
	logic [31:0]       key;
	logic [63:0]       pay_idx;
	logic [1:0]        msg_type;
	logic              msg_open;
	logic              halted;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor
	task automatic emit_result(input wsd_pkg::kind_t k, input logic [7:0] d,
			input logic l);
		result_t r;
		r.k = k; r.d = d; r.l = l;
		expected_results = {expected_results, r};
	endtask

	function automatic bit opcode_known(input logic [3:0] op);
		return op == wsd_pkg::OP_CONT || op == wsd_pkg::OP_TEXT ||
			op == wsd_pkg::OP_BIN || op == wsd_pkg::OP_CLOSE ||
			op == wsd_pkg::OP_PING || op == wsd_pkg::OP_PONG;
	endfunction

	task automatic close_frame();
		if (!opcode_known(opc)) begin
			emit_result(wsd_pkg::KIND_ERROR, 8'h00, 1'b0);
			halted = 1'b1;
		end else if (opc == wsd_pkg::OP_CLOSE) begin
			emit_result(wsd_pkg::KIND_CLOSE, 8'h00, 1'b0);
			halted = 1'b1;
		end else if (opc == wsd_pkg::OP_PING) begin
			if (pay_len == 64'd0) emit_result(wsd_pkg::KIND_PONG_EMPTY, 8'h00, 1'b1);
		end else if (opc == wsd_pkg::OP_CONT || opc == wsd_pkg::OP_TEXT) begin
			if (pay_len == 64'd0 && fin_f && msg_type == 2'd1)
				emit_result(wsd_pkg::KIND_TEXT_END, 8'h00, 1'b1);
		end
		ph = wsd_pkg::PH_HDR0;
	endtask

	task automatic finish_header();
		if (opc == wsd_pkg::OP_TEXT || opc == wsd_pkg::OP_BIN) begin
			// new data frame over an open text message drops the old one
			if (msg_open && msg_type == 2'd1)
				emit_result(wsd_pkg::KIND_DISCARD, 8'h00, 1'b0);
			msg_type = opc[1:0];
			msg_open = !fin_f;
		end else if (opc == wsd_pkg::OP_CONT) begin
			msg_open = !fin_f;
		end
		pay_idx = '0;
		if (pay_len == 64'd0) close_frame();
		else ph = wsd_pkg::PH_PAY;
	endtask

	task automatic finish_length();
		if (pay_len > {32'd0, len_limit}) begin
			halted = 1'b1;
			ph = wsd_pkg::PH_HDR0;
			emit_result(wsd_pkg::KIND_ERROR, 8'h00, 1'b0);
		end else if (masked_f) begin
			hdr_cnt = '0;
			ph = wsd_pkg::PH_MASK;
		end else begin
			finish_header();
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		logic [2:0]  final_cnt;
		int          sh;
		logic [7:0]  d;
		logic        final_b;
		if (halted) return;
		case (ph)
			wsd_pkg::PH_HDR0: begin
				fin_f = b[7];
				opc = b[3:0];
				key = '0;
				ph = wsd_pkg::PH_HDR1;
			end
			wsd_pkg::PH_HDR1: begin
				masked_f = b[7];
				hdr_cnt = '0;
				if (b[6:0] == wsd_pkg::LEN_CODE_16) begin
					pay_len = '0; ph = wsd_pkg::PH_EXT16;
				end else if (b[6:0] == wsd_pkg::LEN_CODE_64) begin
					pay_len = '0; ph = wsd_pkg::PH_EXT64;
				end else begin
					pay_len = {57'd0, b[6:0]};
					finish_length();
				end
			end
			wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
				final_cnt = (ph == wsd_pkg::PH_EXT16) ? 3'd1 : 3'd7;
				pay_len = {pay_len[55:0], b};
				if (hdr_cnt >= final_cnt) finish_length();
				else hdr_cnt = hdr_cnt + 3'd1;
			end
			wsd_pkg::PH_MASK: begin
				key = {key[23:0], b};
				if (hdr_cnt >= 3'd3) finish_header();
				else hdr_cnt = hdr_cnt + 3'd1;
			end
			wsd_pkg::PH_PAY: begin
				sh = 8 * (3 - int'(pay_idx[1:0]));
				d = b ^ 8'((key >> sh) & 32'hFF);
				final_b = (pay_idx + 64'd1 == pay_len);
				if (opc == wsd_pkg::OP_TEXT || (opc == wsd_pkg::OP_CONT && msg_type == 2'd1))
					emit_result(wsd_pkg::KIND_TEXT, d, final_b && fin_f);
				else if (opc == wsd_pkg::OP_PING)
					emit_result(wsd_pkg::KIND_PONG, d, final_b);
				pay_idx = pay_idx + 64'd1;
				if (final_b) close_frame();
			end
			default: ph = wsd_pkg::PH_HDR0;
		endcase
	endtask

	// ---------------------------------------------------------------- stimulus
	task automatic queue_byte(input logic [7:0] b);
		pend_t p;
		p.is_cfg = 1'b0; p.val = {24'd0, b};
		pending_tx = {pending_tx, p};
	endtask

	task automatic queue_cfg(input logic [31:0] v);
		pend_t p;
		p.is_cfg = 1'b1; p.val = v;
		pending_tx = {pending_tx, p};
	endtask

	// len_mode: 0 shortest encoding, 1 at least 16-bit, 2 force 64-bit
	task automatic queue_frame(input bit fin, input logic [3:0] op, input logic [63:0] len,
			input bit msk, input int len_mode, input int body);
		logic [31:0] k;
		queue_byte({fin, $urandom_range(7, 0) == 0 ? 3'($urandom) : 3'b000, op});
		if (len_mode == 0 && len < 64'd126) begin
			queue_byte({msk, len[6:0]});
		end else if (len_mode != 2 && len < 64'd65536) begin
			queue_byte({msk, wsd_pkg::LEN_CODE_16});
			queue_byte(len[15:8]); queue_byte(len[7:0]);
		end else begin
			queue_byte({msk, wsd_pkg::LEN_CODE_64});
			for (int i = 7; i >= 0; i--) queue_byte(len[8*i +: 8]);
		end
		k = $urandom;
		if (msk) for (int i = 3; i >= 0; i--) queue_byte(k[8*i +: 8]);
		for (int i = 0; i < body; i++) queue_byte(8'($urandom));
	endtask

	function automatic int rand_len();
		return ($urandom_range(9, 0) == 0) ? $urandom_range(300, 0) : $urandom_range(12, 0);
	endfunction

	task automatic queue_random_frame(input logic [3:0] op, input bit fin);
		int len, mode;
		len = rand_len();
		mode = $urandom_range(9, 0) < 8 ? 0 : $urandom_range(2, 1);
		queue_frame(fin, op, 64'(len), $urandom_range(3, 0) != 0, mode, len);
	endtask

	task automatic queue_random_message();
		int frags, sel;
		sel = $urandom_range(99, 0);
		if (sel < 70) begin
			frags = $urandom_range(3, 1);
			for (int f = 0; f < frags; f++) begin
				queue_random_frame(f == 0 ? (sel < 45 ? wsd_pkg::OP_TEXT : wsd_pkg::OP_BIN) :
					wsd_pkg::OP_CONT, f == frags - 1);
				if ($urandom_range(4, 0) == 0) queue_random_frame(wsd_pkg::OP_PING, 1'b1);
			end
		end else if (sel < 82) begin
			queue_random_frame(wsd_pkg::OP_PING, 1'b1);
		end else if (sel < 88) begin
			queue_random_frame(wsd_pkg::OP_PONG, 1'b1);
		end else if (sel < 94) begin
			// broken: text left open, then a new data frame
			queue_random_frame(wsd_pkg::OP_TEXT, 1'b0);
			queue_random_frame($urandom_range(1, 0) ? wsd_pkg::OP_TEXT : wsd_pkg::OP_BIN,
				1'b1);
		end else begin
			queue_random_frame(wsd_pkg::OP_CONT, 1'($urandom_range(1, 0)));
		end
	endtask

	function automatic logic [3:0] bad_opcode();
		return $urandom_range(1, 0) ? 4'($urandom_range(7, 3)) : 4'($urandom_range(15, 11));
	endfunction

	// ---------------------------------------------------------------- driver
	function automatic int sender_idle_pct();
		if (bytes_taken < 250) return 34;
		if (bytes_taken < 500) return 81;
		return 0;
	endfunction

	function automatic int receiver_stall_pct();
		if (bytes_taken < 250) return 81;
		if (bytes_taken < 500) return 34;
		return 0;
	endfunction

	always @(posedge clk) begin
		logic nv, ncv, busy, took;
		logic [7:0]  nb;
		logic [31:0] nl;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			in_byte <= 8'h00;
			max_payload_length <= wsd_pkg::MAX_LEN_RESET;
		end else begin
			nv = in_valid; ncv = cfg_valid; nb = in_byte; nl = max_payload_length;
			took = in_valid && in_ready;
			if (took) begin
				deframe_byte(in_byte);
				bytes_taken++;
				nv = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				len_limit = max_payload_length;
				ncv = 1'b0;
			end
			busy = nv || ncv;
			if (took || expected_results.size() != 0) quiet_count = 0;
			else if (quiet_count < QUIET_CYCLES) quiet_count++;
			if (!busy && pending_tx.size() != 0) begin
				if (pending_tx[0].is_cfg) begin
					// only touch the limit once the block has drained
					if (quiet_count >= QUIET_CYCLES) begin
						ncv = 1'b1;
						nl = pending_tx[0].val;
						pending_tx.delete(0);
						quiet_count = 0;
					end
				end else if ($urandom_range(99, 0) >= sender_idle_pct()) begin
					nv = 1'b1;
					nb = pending_tx[0].val[7:0];
					pending_tx.delete(0);
				end
			end
			in_valid <= nv;
			cfg_valid <= ncv;
			in_byte <= nb;
			max_payload_length <= nl;
		end
	end

	// ---------------------------------------------------------------- monitor
	task automatic report_mismatch(input string what);
		$display("[%0d] mismatch: %s", cycle_count, what);
		error_count++;
	endtask

	always @(posedge clk) begin
		result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result kind %0d", kind));
				end else begin
					e = expected_results[0];
					expected_results.delete(0);
					if (kind !== e.k)
						report_mismatch($sformatf("kind %0d, want %0d", kind, e.k));
					if (data_byte !== e.d)
						report_mismatch($sformatf("data %02h, want %02h", data_byte, e.d));
					if (last !== e.l)
						report_mismatch($sformatf("last %0b, want %0b", last, e.l));
				end
			end
			out_ready <= ($urandom_range(99, 0) >= receiver_stall_pct());
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin
		int choice;
		logic [31:0] lim;
		arst_n = 1'b0;
		in_valid = 1'b0; cfg_valid = 1'b0; in_byte = 8'h00;
		max_payload_length = wsd_pkg::MAX_LEN_RESET; out_ready = 1'b0;
		len_limit = wsd_pkg::MAX_LEN_RESET;
		ph = wsd_pkg::PH_HDR0; fin_f = 1'b0; opc = '0; masked_f = 1'b0; pay_len = '0;
		hdr_cnt = '0; key = '0; pay_idx = '0; msg_type = '0; msg_open = 1'b0;
		halted = 1'b0;

		// orphan continuation before any data frame: dropped
		queue_frame(1'b1, wsd_pkg::OP_CONT, 64'd3, 1'b1, 0, 3);
		// extremes of the reset limit are fine here; short directed frames
		queue_frame(1'b0, wsd_pkg::OP_TEXT, 64'd2, 1'b1, 0, 2);
		queue_frame(1'b1, wsd_pkg::OP_PING, 64'd1, 1'b0, 0, 1);
		queue_frame(1'b1, wsd_pkg::OP_CONT, 64'd0, 1'b1, 0, 0);
		queue_frame(1'b1, wsd_pkg::OP_PING, 64'd0, 1'b1, 0, 0);
		queue_frame(1'b1, wsd_pkg::OP_TEXT, 64'd0, 1'b0, 0, 0);
		queue_frame(1'b0, wsd_pkg::OP_TEXT, 64'd1, 1'b1, 1, 1);
		queue_frame(1'b1, wsd_pkg::OP_BIN, 64'd2, 1'b1, 2, 2);
		queue_frame(1'b1, wsd_pkg::OP_CONT, 64'd2, 1'b0, 0, 2);
		queue_frame(1'b1, wsd_pkg::OP_PONG, 64'd1, 1'b1, 0, 1);

		queue_cfg(32'd0);
		queue_frame(1'b1, wsd_pkg::OP_TEXT, 64'd0, 1'b1, 0, 0);
		queue_frame(1'b1, wsd_pkg::OP_PING, 64'd0, 1'b0, 2, 0);
		queue_frame(1'b1, wsd_pkg::OP_BIN, 64'd0, 1'b1, 1, 0);

		queue_cfg(32'hFFFF_FFFF);
		while (pending_tx.size() < 300) queue_random_message();
		queue_cfg(32'd300);
		while (pending_tx.size() < 520) queue_random_message();
		queue_cfg(wsd_pkg::MAX_LEN_RESET);
		while (pending_tx.size() < 740) queue_random_message();

		// one stopping event at the end, since reset comes only once
		choice = $urandom_range(2, 0);
		if (choice == 0) begin
			queue_frame(1'b1, wsd_pkg::OP_CLOSE, 64'd2, 1'b1, 0, 2);
		end else if (choice == 1) begin
			queue_frame(1'b1, bad_opcode(), $urandom_range(1, 0) ? 64'd0 : 64'd3, 1'b1, 0, 3);
		end else begin
			lim = $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'd5;
			queue_cfg(lim);
			queue_frame(1'b1, wsd_pkg::OP_TEXT, lim == 32'd5 ? 64'd9 : {1'b1, 63'd3},
				1'b1, 0, 4);
		end
		// ignored tail
		for (int i = 0; i < 6; i++) queue_byte(8'($urandom));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_tx.size() == 0 && !in_valid && !cfg_valid &&
			expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: websocket_frame_deframer.f
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_parser.sv
hw/rtl/wsd_queue.sv
hw/rtl/wsd_emitter.sv
hw/rtl/websocket_frame_deframer.sv
tb/tb_top.sv
